>>> rtl/core/kcl_pkg.sv
// ----------------------------------------------------------------------------
// Keypad code lock package
// Shared widths, key codes, event and mode encodings and the queue item type.
// ----------------------------------------------------------------------------
package kcl_pkg;

  localparam int unsigned KeyW   = 8;
  localparam int unsigned EventW = 4;
  localparam int unsigned DigW   = 3;
  localparam int unsigned ModeW  = 2;
  localparam int unsigned LimitW = 4;

  localparam logic [KeyW-1:0]   KEY_STAR        = 8'h2A;
  localparam logic [KeyW-1:0]   KEY_HASH        = 8'h23;
  localparam logic [LimitW-1:0] WRONG_LIMIT_RST = 4'd3;

  typedef logic [KeyW-1:0]   key_t;
  typedef logic [LimitW-1:0] limit_t;
  typedef logic [DigW-1:0]   digits_t;

  typedef enum logic [EventW-1:0] {
    EV_IGNORED  = 4'd0,
    EV_DIGIT    = 4'd1,
    EV_SET      = 4'd2,
    EV_MISMATCH = 4'd3,
    EV_OPEN     = 4'd4,
    EV_WRONG    = 4'd5,
    EV_ALARM    = 4'd6,
    EV_RESET    = 4'd7,
    EV_PROMPT   = 4'd8
  } event_e;

  typedef enum logic [ModeW-1:0] {
    MODE_SETUP1 = 2'd0,
    MODE_SETUP2 = 2'd1,
    MODE_IDLE   = 2'd2,
    MODE_ENTER  = 2'd3
  } mode_e;

  // Classified key as it travels from the front to the back
  typedef struct packed {
    logic is_star;
    logic is_hash;
    key_t key;
  } key_item_t;

endpackage

>>> rtl/core/kcl_if.sv
// ----------------------------------------------------------------------------
// Keypad code lock channel interfaces
// Valid/ready channels for key beats, result beats and the limit register.
// ----------------------------------------------------------------------------
interface kcl_key_if;
  logic          valid;
  logic          ready;
  kcl_pkg::key_t key_code;

  modport source (output valid, output key_code, input ready);
  modport sink   (input valid, input key_code, output ready);
endinterface

interface kcl_res_if;
  logic             valid;
  logic             ready;
  kcl_pkg::event_e  event_res;
  kcl_pkg::digits_t digits_entered;
  kcl_pkg::mode_e   lock_mode;

  modport source (output valid, output event_res, output digits_entered,
                  output lock_mode, input ready);
  modport sink   (input valid, input event_res, input digits_entered,
                  input lock_mode, output ready);
endinterface

interface kcl_cfg_if;
  logic            valid;
  logic            ready;
  kcl_pkg::limit_t wrong_limit;

  modport source (output valid, output wrong_limit, input ready);
  modport sink   (input valid, input wrong_limit, output ready);
endinterface

>>> rtl/core/kcl_front.sv
// ----------------------------------------------------------------------------
// Keypad code lock front end
// Accepts key beats, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
module kcl_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  kcl_key_if.sink            key_i,
  output logic               item_valid_o,
  output kcl_pkg::key_item_t item_o,
  input  logic               item_pop_i
);
  import kcl_pkg::*;

  key_item_t  mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push, pop;
  key_item_t  item_in;

  // Classify the incoming key
  always_comb begin
    item_in.key     = key_i.key_code;
    item_in.is_star = (key_i.key_code == KEY_STAR);
    item_in.is_hash = (key_i.key_code == KEY_HASH);
  end

  assign key_i.ready  = (count_q != 2'd2);
  assign push         = key_i.valid && key_i.ready;
  assign pop          = item_pop_i && (count_q != 2'd0);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the classified beat
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

endmodule

>>> rtl/core/kcl_back.sv
// ----------------------------------------------------------------------------
// Keypad code lock back end
// Runs the lock state machine on queued keys and drives the result register.
// ----------------------------------------------------------------------------
module kcl_back #(
  parameter int unsigned CODE_LEN = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               item_valid_i,
  input  kcl_pkg::key_item_t item_i,
  output logic               item_pop_o,
  kcl_cfg_if.sink            cfg_i,
  kcl_res_if.source          res_o
);
  import kcl_pkg::*;

  localparam int unsigned CntW = $clog2(CODE_LEN + 1);
  localparam int unsigned IdxW = (CODE_LEN > 1) ? $clog2(CODE_LEN) : 1;
  localparam int unsigned ExtW = CntW + DigW;

  mode_e                        mode_q, mode_d;
  logic [CntW-1:0]              cnt_q, cnt_d, cnt_inc;
  logic [LimitW-1:0]            wrong_q, wrong_d, wrong_inc;
  limit_t                       limit_q;
  logic [CODE_LEN-1:0][KeyW-1:0] entry_q, entry_nx;
  logic [CODE_LEN-1:0][KeyW-1:0] first_q;
  logic [CODE_LEN-1:0][KeyW-1:0] stored_q;
  logic [IdxW-1:0]              wr_idx;
  logic                         take, done;
  logic                         first_we, entry_we, store_we;
  event_e                       ev;
  logic [ExtW-1:0]              cnt_ext;

  logic    out_valid_q;
  event_e  out_ev_q;
  digits_t out_dig_q;
  mode_e   out_mode_q;

  // Take a key when the result register is free or being drained
  assign take       = item_valid_i && (!out_valid_q || res_o.ready);
  assign item_pop_o = take;
  assign cfg_i.ready = 1'b1;

  assign wr_idx  = cnt_q[IdxW-1:0];
  assign cnt_inc = cnt_q + CntW'(1);
  assign done    = (cnt_inc == CntW'(CODE_LEN));

  // Entry buffer with the current key placed
  always_comb begin
    entry_nx         = entry_q;
    entry_nx[wr_idx] = item_i.key;
  end

  assign wrong_inc = wrong_q + LimitW'(1);

  // Next state and event
  always_comb begin
    mode_d   = mode_q;
    cnt_d    = cnt_q;
    wrong_d  = wrong_q;
    ev       = EV_IGNORED;
    first_we = 1'b0;
    entry_we = 1'b0;
    store_we = 1'b0;
    unique case (mode_q)
      MODE_SETUP1: begin
        first_we = 1'b1;
        if (done) begin
          mode_d = MODE_SETUP2;
          cnt_d  = '0;
          ev     = EV_PROMPT;
        end else begin
          cnt_d = cnt_inc;
          ev    = EV_DIGIT;
        end
      end
      MODE_SETUP2: begin
        entry_we = 1'b1;
        if (done) begin
          cnt_d = '0;
          if (entry_nx == first_q) begin
            store_we = 1'b1;
            mode_d   = MODE_IDLE;
            ev       = EV_SET;
          end else begin
            mode_d = MODE_SETUP1;
            ev     = EV_MISMATCH;
          end
        end else begin
          cnt_d = cnt_inc;
          ev    = EV_DIGIT;
        end
      end
      MODE_IDLE: begin
        priority if (item_i.is_star) begin
          mode_d = MODE_SETUP1;
          cnt_d  = '0;
          ev     = EV_RESET;
        end else if (item_i.is_hash) begin
          mode_d = MODE_ENTER;
          cnt_d  = '0;
          ev     = EV_PROMPT;
        end else begin
          ev = EV_IGNORED;
        end
      end
      MODE_ENTER: begin
        entry_we = 1'b1;
        if (done) begin
          cnt_d  = '0;
          mode_d = MODE_IDLE;
          if (entry_nx == stored_q) begin
            ev = EV_OPEN;
          end else if (wrong_inc >= limit_q) begin
            wrong_d = '0;
            ev      = EV_ALARM;
          end else begin
            wrong_d = wrong_inc;
            ev      = EV_WRONG;
          end
        end else begin
          cnt_d = cnt_inc;
          ev    = EV_DIGIT;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
  end

  assign cnt_ext = ExtW'(cnt_d);

  // Hold control state and the limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_SETUP1;
      cnt_q       <= '0;
      wrong_q     <= '0;
      limit_q     <= WRONG_LIMIT_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        limit_q <= cfg_i.wrong_limit;
      end
      if (take) begin
        mode_q      <= mode_d;
        cnt_q       <= cnt_d;
        wrong_q     <= wrong_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Code buffers and result payload
  always_ff @(posedge clk_i) begin
    if (take) begin
      if (first_we) begin
        first_q[wr_idx] <= item_i.key;
      end
      if (entry_we) begin
        entry_q <= entry_nx;
      end
      if (store_we) begin
        stored_q <= entry_nx;
      end
      out_ev_q   <= ev;
      out_dig_q  <= cnt_ext[DigW-1:0];
      out_mode_q <= mode_d;
    end
  end

  assign res_o.valid          = out_valid_q;
  assign res_o.event_res      = out_ev_q;
  assign res_o.digits_entered = out_dig_q;
  assign res_o.lock_mode      = out_mode_q;

endmodule

>>> rtl/core/keypad_code_lock.sv
// Path: a key beat is written into the front-end queue and, once the back
// end takes it, into the result register; one result beat per key.
// Throughput: one key per cycle while the result side takes every beat; a
// two-entry queue between front and back absorbs short result stalls.
// Reset: rst_ni clears mode, digit count, wrong count and queue at once;
// the wrong limit returns to 3 and stored codes are undefined until set.
// ----------------------------------------------------------------------------
// Keypad code lock top level
// Key classification front end, queue, and lock state machine back end.
// ----------------------------------------------------------------------------
module keypad_code_lock #(
  parameter int unsigned CODE_LEN = 4
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  kcl_key_if.sink    key_i,
  kcl_cfg_if.sink    cfg_i,
  kcl_res_if.source  res_o
);
  import kcl_pkg::*;

  logic      item_valid;
  logic      item_pop;
  key_item_t item;

  kcl_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_i        (key_i),
    .item_valid_o (item_valid),
    .item_o       (item),
    .item_pop_i   (item_pop)
  );

  kcl_back #(
    .CODE_LEN (CODE_LEN)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .item_pop_o   (item_pop),
    .cfg_i        (cfg_i),
    .res_o        (res_o)
  );

endmodule

>>> rtl/core/kcl_checker.sv
// ----------------------------------------------------------------------------
// Keypad code lock port checker
// Watches result beats for handshake holding and event/mode consistency.
// ----------------------------------------------------------------------------
module kcl_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             res_valid_i,
  input logic             res_ready_i,
  input kcl_pkg::event_e  event_res_i,
  input kcl_pkg::digits_t digits_i,
  input kcl_pkg::mode_e   mode_i
);
  import kcl_pkg::*;

  // Hold a stalled result beat
  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result beat dropped while stalled");

  a_payload_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      $stable(event_res_i) && $stable(digits_i) && $stable(mode_i))
    else $error("stalled result payload changed");

  // Idle menu never shows a partial code
  a_idle_digits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && mode_i == MODE_IDLE |-> digits_i == '0)
    else $error("digits left over in idle menu");

  // Completion events land in the matching mode
  a_event_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && (event_res_i == EV_SET || event_res_i == EV_OPEN ||
                    event_res_i == EV_WRONG || event_res_i == EV_ALARM)
      |-> mode_i == MODE_IDLE && digits_i == '0)
    else $error("completion event outside idle menu");

endmodule

bind keypad_code_lock kcl_checker u_kcl_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .event_res_i (res_o.event_res),
  .digits_i    (res_o.digits_entered),
  .mode_i      (res_o.lock_mode)
);

>>> bench/tb_keypad_code_lock.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Keypad code lock testbench
// Drives key beats with random gaps into the lock. A local model of the lock
// predicts each result beat, which is checked field by field as it arrives.
// Results are taken with random stalls. Directed tests cover setup, the menu,
// door open, wrong entries and the alarm limit. They are followed by a
// back-pressure test and a random run of mostly well-formed code sequences.
// ----------------------------------------------------------------------------
module tb_keypad_code_lock;
  import kcl_pkg::*;

  localparam int unsigned CodeLen     = 4;
  localparam int unsigned DrainCycles = 4;
  localparam int unsigned CycleLimit  = 200000;

  typedef logic [CodeLen*KeyW-1:0] code_t;

  typedef struct packed {
    event_e  ev;
    digits_t digits;
    mode_e   md;
  } lock_res_t;

  logic clk;
  logic rst_n;

  kcl_key_if key_if ();
  kcl_cfg_if cfg_if ();
  kcl_res_if res_if ();

  keypad_code_lock #(
    .CODE_LEN(CodeLen)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .key_i (key_if),
    .cfg_i (cfg_if),
    .res_o (res_if)
  );

  // Lock model state
  mode_e       lk_mode;
  int unsigned lk_count;
  logic [3:0]  lk_wrongs;
  limit_t      lk_limit;
  code_t       lk_entry;
  code_t       lk_first;
  code_t       lk_code;

  lock_res_t   lock_q[$];
  int unsigned n_taken;
  int unsigned n_errors;
  int unsigned n_results;
  int unsigned n_cycles;
  int unsigned hold_req;
  int unsigned res_wait;
  bit          no_idle;

  // Clock
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Work out the result beat that one key causes and advance the lock model
  function automatic lock_res_t lock_step(input key_t k);
    lock_res_t r;
    logic      full;
    r.ev = EV_IGNORED;
    full = 1'b0;
    // every key counts as a digit outside the idle menu
    if (lk_mode != MODE_IDLE) begin
      if (lk_count >= CodeLen) lk_count = 0;
      if (lk_mode == MODE_SETUP1) lk_first[lk_count*KeyW +: KeyW] = k;
      else lk_entry[lk_count*KeyW +: KeyW] = k;
      lk_count++;
      if (lk_count >= CodeLen) begin
        lk_count = 0;
        full = 1'b1;
      end
    end
    case (lk_mode)
      MODE_SETUP1: begin
        if (full) begin
          lk_mode = MODE_SETUP2;
          r.ev = EV_PROMPT;
        end else r.ev = EV_DIGIT;
      end
      MODE_SETUP2: begin
        if (full) begin
          if (lk_entry == lk_first) begin
            lk_code = lk_entry;
            lk_mode = MODE_IDLE;
            r.ev = EV_SET;
          end else begin
            lk_mode = MODE_SETUP1;
            r.ev = EV_MISMATCH;
          end
        end else r.ev = EV_DIGIT;
      end
      MODE_IDLE: begin
        if (k == KEY_STAR) begin
          lk_mode = MODE_SETUP1;
          lk_count = 0;
          r.ev = EV_RESET;
        end else if (k == KEY_HASH) begin
          lk_mode = MODE_ENTER;
          lk_count = 0;
          r.ev = EV_PROMPT;
        end
      end
      default: begin
        if (full) begin
          lk_mode = MODE_IDLE;
          if (lk_code == lk_entry) r.ev = EV_OPEN;
          else begin
            lk_wrongs = lk_wrongs + 4'd1;
            if (lk_wrongs >= lk_limit) begin
              lk_wrongs = '0;
              r.ev = EV_ALARM;
            end else r.ev = EV_WRONG;
          end
        end else r.ev = EV_DIGIT;
      end
    endcase
    r.digits = digits_t'(lk_count);
    r.md = lk_mode;
    return r;
  endfunction

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 10);
  endfunction

  function automatic key_t pick_key();
    case ($urandom_range(0, 9))
      0:       return KEY_STAR;
      1:       return KEY_HASH;
      default: return key_t'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic code_t pick_code();
    code_t c;
    for (int i = 0; i < CodeLen; i++) c[i*KeyW +: KeyW] = pick_key();
    return c;
  endfunction

  function automatic code_t flip_bit(input code_t c);
    return c ^ (code_t'(1) << $urandom_range(0, CodeLen*KeyW-1));
  endfunction

  task automatic flag_error(input string what);
    n_errors++;
    if (n_errors <= 10) $display("%s", what);
  endtask

  // Offer one key beat after a random gap and log its expected result
  task automatic send_key(input key_t k);
    int unsigned gap;
    lock_res_t   r;
    gap = draw_wait();
    if (gap > 0) begin
      key_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    key_if.valid    <= 1'b1;
    key_if.key_code <= k;
    do @(posedge clk); while (!key_if.ready);
    r = lock_step(k);
    lock_q.push_back(r);
    n_taken++;
  endtask

  task automatic send_code(input code_t c);
    for (int i = 0; i < CodeLen; i++) send_key(c[i*KeyW +: KeyW]);
  endtask

  // Stop offering keys and wait until every expected result has arrived
  task automatic drain();
    key_if.valid <= 1'b0;
    while (lock_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_limit(input limit_t v);
    drain();
    cfg_if.valid       <= 1'b1;
    cfg_if.wrong_limit <= v;
    do @(posedge clk); while (!cfg_if.ready);
    lk_limit = v;
    cfg_if.valid <= 1'b0;
  endtask

  // Setup: digits include both extremes and the two special keys; a
  // mismatched repeat sends setup back to the start
  task automatic test_setup();
    code_t c;
    c = {KEY_HASH, KEY_STAR, 8'hFF, 8'h00};
    send_code(c);
    send_code({KEY_STAR, KEY_HASH, 8'hFF, 8'h00});
    send_code(c);
    send_code(c);
  endtask

  // Menu: other keys are ignored, '#' prompts and the right code opens
  task automatic test_menu_open();
    send_key(8'h55);
    send_key(KEY_HASH);
    send_code(lk_code);
  endtask

  // Wrong count at the top limit, across a return to setup, then against a
  // limit equal to the count and a limit of zero
  task automatic test_limit_count();
    write_limit(limit_t'(15));
    send_key(KEY_HASH);
    send_code(flip_bit(lk_code));
    send_key(KEY_STAR);
    send_code(lk_code);
    send_code(lk_code);
    write_limit(limit_t'(1));
    send_key(KEY_HASH);
    send_code(~lk_code);
    write_limit(limit_t'(0));
    send_key(KEY_HASH);
    send_code(flip_bit(lk_code));
    write_limit(WRONG_LIMIT_RST);
  endtask

  // Mostly complete code sequences with random content, some noise keys
  task automatic test_random();
    int unsigned goal;
    int unsigned r;
    code_t       c;
    goal = n_taken + 900;
    while (n_taken < goal) begin
      if ($urandom_range(0, 149) == 0) begin
        case ($urandom_range(0, 3))
          0:       write_limit(limit_t'(1));
          1:       write_limit(limit_t'(15));
          default: write_limit(limit_t'($urandom_range(1, 15)));
        endcase
        no_idle = ($urandom_range(0, 3) == 0);
      end
      r = $urandom_range(0, 99);
      if (r < 10) send_key(pick_key());
      else begin
        case (lk_mode)
          MODE_IDLE: begin
            if (r < 60) send_key(KEY_HASH);
            else if (r < 72) send_key(KEY_STAR);
            else send_key(key_t'($urandom_range(0, 255)));
          end
          MODE_ENTER: begin
            if (lk_count != 0) send_key(pick_key());
            else if (r < 55) send_code(lk_code);
            else if (r < 85) send_code(flip_bit(lk_code));
            else send_code(pick_code());
          end
          MODE_SETUP1: begin
            if (lk_count != 0) send_key(pick_key());
            else begin
              c = pick_code();
              send_code(c);
              send_code((r < 80) ? c : flip_bit(c));
            end
          end
          default: send_key(pick_key());
        endcase
      end
    end
  endtask

  // Hold results off long enough for the key side to stall, then pause the
  // sender until everything is back
  task automatic test_backpressure();
    drain();
    no_idle  = 1'b1;
    hold_req = 80;
    repeat (12) send_key(pick_key());
    drain();
    no_idle = 1'b0;
  endtask

  // Result side: random stall per beat, or a long hold-off on request
  always @(posedge clk) begin
    if (hold_req > 0) begin
      res_wait = hold_req;
      hold_req = 0;
    end else if (res_if.valid && res_if.ready) res_wait = draw_wait();
    else if (res_wait > 0) res_wait--;
    res_if.ready <= (res_wait == 0);
  end

  // Compare each result beat with the oldest expectation
  always @(posedge clk) begin
    lock_res_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      n_results++;
      if (lock_q.size() == 0) begin
        flag_error($sformatf("result %0d: unexpected beat, event %0d digits %0d mode %0d",
                             n_results, res_if.event_res, res_if.digits_entered,
                             res_if.lock_mode));
      end else begin
        want = lock_q.pop_front();
        if (res_if.event_res !== want.ev || res_if.digits_entered !== want.digits ||
            res_if.lock_mode !== want.md) begin
          flag_error($sformatf(
            "result %0d: expected event %0d digits %0d mode %0d, got %0d %0d %0d",
            n_results, want.ev, want.digits, want.md, res_if.event_res,
            res_if.digits_entered, res_if.lock_mode));
        end
      end
    end
  end

  // Give up on a hung run
  always @(posedge clk) begin
    n_cycles++;
    if (n_cycles > CycleLimit) begin
      $display("tb_keypad_code_lock failed");
      $finish;
    end
  end

  initial begin
    rst_n              = 1'b0;
    key_if.valid       = 1'b0;
    key_if.key_code    = '0;
    cfg_if.valid       = 1'b0;
    cfg_if.wrong_limit = WRONG_LIMIT_RST;
    res_if.ready       = 1'b0;
    lk_mode            = MODE_SETUP1;
    lk_count           = 0;
    lk_wrongs          = '0;
    lk_limit           = WRONG_LIMIT_RST;
    lk_entry           = '0;
    lk_first           = '0;
    lk_code            = '0;
    n_taken            = 0;
    n_errors           = 0;
    n_results          = 0;
    n_cycles           = 0;
    hold_req           = 0;
    res_wait           = 0;
    no_idle            = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_setup();
    test_menu_open();
    test_limit_count();
    test_backpressure();
    test_random();
    drain();

    if (n_errors == 0) $display("tb_keypad_code_lock passed");
    else $display("tb_keypad_code_lock failed");
    $finish;
  end

endmodule

>>> files.f
rtl/core/kcl_pkg.sv
rtl/core/kcl_if.sv
rtl/core/kcl_front.sv
rtl/core/kcl_back.sv
rtl/core/keypad_code_lock.sv
rtl/core/kcl_checker.sv
bench/tb_keypad_code_lock.sv
